FILE: src/plsi_pkg.sv
// Shared types, constants and state encoding of the polyline intersection block.
// Used by every module in src; depends on nothing.
`default_nettype none

package plsi_pkg;

    // table geometry
    localparam int NUM_VERTICES = 256;
    localparam int VIDX_W       = $clog2(NUM_VERTICES);

    // field and datapath widths
    localparam int COORD_W   = 32;
    localparam int SPACING_W = 31;
    localparam int QX_W      = VIDX_W + SPACING_W;   // vertex x, unsigned
    localparam int DX_W      = QX_W + 2;             // query x minus vertex x
    localparam int DIFF_W    = COORD_W + 1;          // difference of two coordinates
    localparam int QUO_W     = COORD_W + 1;          // signed window quotient
    localparam int WIN_W     = QUO_W + 1;            // window bound before clamping
    localparam int T_BITS    = 30;
    localparam int TQ_W      = T_BITS + 1;

    // multiplier: a up to 34 bits signed, b up to 42 bits signed in three chunks
    localparam int MA_W    = DIFF_W + 1;
    localparam int CHUNK_W = 14;
    localparam int NCHUNK  = 3;
    localparam int MB_W    = CHUNK_W * NCHUNK;
    localparam int PP_W    = MA_W + CHUNK_W;
    localparam int PROD_W  = MA_W + MB_W;

    localparam logic [SPACING_W-1:0]      SPACING_RESET = SPACING_W'(65536);
    localparam logic signed [COORD_W-1:0] HQ_TOP        = 32'sd65536000;
    localparam logic signed [COORD_W-1:0] HQ_BOTTOM     = -32'sd65536000;

    // operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SEG    = 2'd1;
    localparam logic [1:0] OP_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic [7:0]                vertex_index;
        logic signed [COORD_W-1:0] vertex_height;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [VIDX_W-1:0] addr;
        logic [COORD_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              re;
        logic [VIDX_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic                   start;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] dividend;
        logic [SPACING_W-1:0]      divisor;
    } div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_QMIN_GO,
        ST_QMIN_WAIT,
        ST_QMAX_GO,
        ST_QMAX_WAIT,
        ST_WINDOW,
        ST_READ0,
        ST_READ1,
        ST_SETUP,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_NORM,
        ST_CHECK,
        ST_DIVT,
        ST_UPDATE,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_ROUND,
        ST_POINT,
        ST_OUT
    } core_state_t;

endpackage

`default_nettype wire

FILE: src/plsi_height_ram.sv
// Height table: one write port, one registered read port, valid bits per entry.
// Depends on plsi_pkg for the table size and port structs.
`default_nettype none

module plsi_height_ram (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire plsi_pkg::ram_wr_t             wr,
    input  wire plsi_pkg::ram_rd_t             rd,
    output logic [plsi_pkg::COORD_W-1:0]       rd_data
);
    import plsi_pkg::*;

    logic [COORD_W-1:0]      mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] valid_reg;
    logic [COORD_W-1:0]      q_reg;
    logic                    q_ok_reg;

    // storage array, no reset
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.re) begin
            q_reg <= mem[rd.addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            q_ok_reg  <= 1'b0;
        end else begin
            if (wr.we) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.re) begin
                q_ok_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = q_ok_reg ? q_reg : '0;

endmodule

`default_nettype wire

FILE: src/plsi_mul.sv
// Signed multiplier, 34 x 42 bits, one 14-bit chunk of b per cycle.
// Depends on plsi_pkg for widths and the request struct.
`default_nettype none

module plsi_mul (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire plsi_pkg::mul_req_t                 req,
    output logic                                    done,
    output logic signed [plsi_pkg::PROD_W-1:0]      res
);
    import plsi_pkg::*;

    logic [MA_W-1:0]   mag_a_reg;
    logic [MB_W-1:0]   mag_b_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [1:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic signed [PROD_W-1:0] res_reg;
    logic [CHUNK_W-1:0] chunk;
    logic [PP_W-1:0]    pp;
    logic [PROD_W-1:0]  pp_sh;

    // current chunk and its shifted partial product
    always_comb begin
        unique case (cnt_reg)
            2'd0:    chunk = mag_b_reg[CHUNK_W-1:0];
            2'd1:    chunk = mag_b_reg[2*CHUNK_W-1:CHUNK_W];
            2'd2:    chunk = mag_b_reg[3*CHUNK_W-1:2*CHUNK_W];
            default: chunk = '0;
        endcase
        pp = PP_W'(mag_a_reg) * PP_W'(chunk);
        unique case (cnt_reg)
            2'd0:    pp_sh = PROD_W'(pp);
            2'd1:    pp_sh = PROD_W'(pp) << CHUNK_W;
            2'd2:    pp_sh = PROD_W'(pp) << (2 * CHUNK_W);
            default: pp_sh = '0;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(NCHUNK)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitudes, accumulation and sign
    always_ff @(posedge aclk) begin
        if (req.start) begin
            mag_a_reg <= req.a[MA_W-1] ? MA_W'(-req.a) : MA_W'(req.a);
            mag_b_reg <= req.b[MB_W-1] ? MB_W'(-req.b) : MB_W'(req.b);
            neg_reg   <= req.a[MA_W-1] ^ req.b[MB_W-1];
            acc_reg   <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == 2'(NCHUNK)) begin
                res_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
            end else begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

FILE: src/plsi_win_div.sv
// Restoring divider for the window bounds: signed x over unsigned spacing,
// truncating toward zero, one quotient bit per cycle. Depends on plsi_pkg.
`default_nettype none

module plsi_win_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire plsi_pkg::div_req_t                req,
    output logic                                   done,
    output logic signed [plsi_pkg::QUO_W-1:0]      quotient
);
    import plsi_pkg::*;

    logic [COORD_W-1:0]   num_reg;
    logic [SPACING_W-1:0] rem_reg;
    logic [SPACING_W-1:0] div_reg;
    logic                 neg_reg;
    logic [4:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [QUO_W-1:0] quo_reg;
    logic [SPACING_W:0]   rem_sh;
    logic                 ge;
    logic [SPACING_W:0]   rem_sub;
    logic [COORD_W-1:0]   num_n;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, num_reg[COORD_W-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_sub = rem_sh - {1'b0, div_reg};
        num_n   = {num_reg[COORD_W-2:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(COORD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.dividend[COORD_W-1] ? COORD_W'(-req.dividend)
                                                : COORD_W'(req.dividend);
            neg_reg <= req.dividend[COORD_W-1];
            div_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_n;
            rem_reg <= ge ? rem_sub[SPACING_W-1:0] : rem_sh[SPACING_W-1:0];
            if (cnt_reg == 5'(COORD_W - 1)) begin
                quo_reg <= neg_reg ? -$signed(QUO_W'(num_n)) : $signed(QUO_W'(num_n));
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/polyline_segment_intersect_core.sv
// Top level of the terrain polyline intersection block: sequencer, window,
// cross products, t division and point scaling. Depends on plsi_pkg,
// plsi_height_ram, plsi_mul and plsi_win_div.
//
// One request at a time. A height write gives no result. A query first
// finds its window (two 32-step divisions of x by the spacing, then the
// bounds), then for each terrain segment in the window does the two table
// reads and setup, six products for three cross products through the shared
// chunked multiplier, the sign fix and range check, the bit-serial division
// of t if needed, and a step that keeps the nearest hit; the point is then
// scaled through the same multiplier, x and then y, and the result is
// registered. A typical window holds three or four segments; a query
// spanning far in x walks up to NUM_VERTICES-1 of them. The result waits in
// an output register, and a new request is taken once that register is free.
// Heights read zero after reset through per-entry valid bits, with no pass.
`default_nettype none

module polyline_segment_intersect_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire plsi_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output plsi_pkg::out_item_t                  m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [plsi_pkg::SPACING_W-1:0]  cfg_wr_data
);
    import plsi_pkg::*;

    localparam logic signed [WIN_W-1:0] LAST_S = WIN_W'(NUM_VERTICES - 1);

    core_state_t state_reg, state_next;

    logic [SPACING_W-1:0] spacing_reg;
    logic [SPACING_W-1:0] sp;

    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [DIFF_W-1:0]  s1x_reg, s1y_reg;
    logic signed [QUO_W-1:0]   qmin_reg, qmax_reg;
    logic [VIDX_W-1:0]         i_reg, hi_reg;
    logic [QX_W-1:0]           qx_reg;
    logic signed [COORD_W-1:0] h0_reg;
    logic signed [DIFF_W-1:0]  s2y_reg, dy_reg;
    logic signed [DX_W-1:0]    dx_reg;
    logic [2:0]                pidx_reg;
    logic signed [PROD_W-1:0]  den_reg, sn_reg, tn_reg;
    logic [PROD_W:0]           rdiv_reg;
    logic [TQ_W-1:0]           qt_reg, tq_reg, best_reg;
    logic [4:0]                tcnt_reg;
    logic                      seg_hit_reg, found_reg, sel_reg;
    logic [PROD_W-1:0]         mag_reg;
    logic                      neg_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic                      m_valid_reg;
    out_item_t                 m_data_reg;

    ram_wr_t                   ram_wr;
    ram_rd_t                   ram_rd;
    logic [COORD_W-1:0]        ram_q;
    mul_req_t                  mul_req;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_res;
    div_req_t                  div_req;
    logic                      div_done;
    logic signed [QUO_W-1:0]   div_q;

    logic                      accept, out_free, is_query;
    logic signed [WIN_W-1:0]   lo_w, hi_w, lo_c, hi_c;
    logic                      win_empty, more_segs, check_fail, t_is_one, tdiv_last;
    logic [PROD_W:0]           r_sh, den_ext;
    logic                      t_ge;
    logic [TQ_W-1:0]           qt_n;
    logic [PROD_W-1:0]         rnd;
    logic [COORD_W-1:0]        pval, sval;
    logic signed [COORD_W-1:0] pbase;

    plsi_height_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_q)
    );

    plsi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .res     (mul_res)
    );

    plsi_win_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // spacing register, zero acts as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= SPACING_RESET;
        end else if (cfg_wr_en) begin
            spacing_reg <= cfg_wr_data;
        end
    end
    assign sp = (spacing_reg == '0) ? SPACING_W'(1) : spacing_reg;

    // handshake and condition terms
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_query = (s_data.operation == OP_SEG) || (s_data.operation == OP_HEIGHT);

    // window bounds, clamped to the table
    always_comb begin
        lo_w      = WIN_W'(qmin_reg) - WIN_W'(1);
        hi_w      = WIN_W'(qmax_reg) + WIN_W'(2);
        lo_c      = (lo_w < 0) ? '0 : lo_w;
        hi_c      = (hi_w > LAST_S) ? LAST_S : hi_w;
        win_empty = lo_c >= hi_c;
    end

    assign more_segs = ({1'b0, i_reg} + (VIDX_W+1)'(1)) < {1'b0, hi_reg};

    // range tests on s and t after the sign fix
    assign check_fail = (den_reg == '0) || sn_reg[PROD_W-1] || (sn_reg > den_reg)
                        || tn_reg[PROD_W-1] || (tn_reg > den_reg);
    assign t_is_one   = tn_reg == den_reg;

    // one step of the t division
    always_comb begin
        r_sh      = {rdiv_reg[PROD_W-1:0], 1'b0};
        den_ext   = {1'b0, den_reg};
        t_ge      = r_sh >= den_ext;
        qt_n      = {qt_reg[TQ_W-2:0], t_ge};
        tdiv_last = tcnt_reg == 5'(T_BITS - 1);
    end

    // rounding of t times the query delta
    always_comb begin
        rnd   = mag_reg + (PROD_W'(1) << (T_BITS - 1));
        pval  = rnd[T_BITS+COORD_W-1:T_BITS];
        sval  = neg_reg ? -pval : pval;
        pbase = sel_reg ? y1_reg : x1_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (accept && is_query) state_next = ST_QMIN_GO;
            ST_QMIN_GO:    state_next = ST_QMIN_WAIT;
            ST_QMIN_WAIT:  if (div_done) state_next = ST_QMAX_GO;
            ST_QMAX_GO:    state_next = ST_QMAX_WAIT;
            ST_QMAX_WAIT:  if (div_done) state_next = ST_WINDOW;
            ST_WINDOW:     state_next = win_empty ? ST_OUT : ST_READ0;
            ST_READ0:      state_next = ST_READ1;
            ST_READ1:      state_next = ST_SETUP;
            ST_SETUP:      state_next = ST_MUL_GO;
            ST_MUL_GO:     state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    state_next = (pidx_reg == 3'd5) ? ST_NORM : ST_MUL_GO;
                end
            end
            ST_NORM:       state_next = ST_CHECK;
            ST_CHECK: begin
                if (check_fail || t_is_one) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_DIVT;
                end
            end
            ST_DIVT:       if (tdiv_last) state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (more_segs) begin
                    state_next = ST_READ0;
                end else if (found_reg || seg_hit_reg) begin
                    state_next = ST_SCALE_GO;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SCALE_GO:   state_next = ST_SCALE_WAIT;
            ST_SCALE_WAIT: if (mul_done) state_next = ST_ROUND;
            ST_ROUND:      state_next = ST_POINT;
            ST_POINT:      state_next = sel_reg ? ST_OUT : ST_SCALE_GO;
            ST_OUT:        if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // state outputs: ready, table ports and unit requests
    always_comb begin
        s_ready       = 1'b0;
        ram_wr.we     = 1'b0;
        ram_wr.addr   = s_data.vertex_index[VIDX_W-1:0];
        ram_wr.data   = s_data.vertex_height;
        ram_rd.re     = 1'b0;
        ram_rd.addr   = i_reg;
        mul_req.start = 1'b0;
        mul_req.a     = MA_W'(s1x_reg);
        mul_req.b     = MB_W'(s2y_reg);
        div_req.start    = 1'b0;
        div_req.dividend = (x1_reg < x2_reg) ? x1_reg : x2_reg;
        div_req.divisor  = sp;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ram_wr.we = s_valid && (s_data.operation == OP_WRITE)
                            && (32'(s_data.vertex_index) < 32'(NUM_VERTICES));
            end
            ST_QMIN_GO: div_req.start = 1'b1;
            ST_QMAX_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = (x1_reg < x2_reg) ? x2_reg : x1_reg;
            end
            ST_READ0: ram_rd.re = 1'b1;
            ST_READ1: begin
                ram_rd.re   = 1'b1;
                ram_rd.addr = i_reg + VIDX_W'(1);
            end
            ST_MUL_GO: begin
                mul_req.start = 1'b1;
                unique case (pidx_reg)
                    3'd0: begin mul_req.a = MA_W'(s1x_reg); mul_req.b = MB_W'(s2y_reg); end
                    3'd1: begin
                        mul_req.a = MA_W'(s1y_reg);
                        mul_req.b = $signed(MB_W'(sp));
                    end
                    3'd2: begin mul_req.a = MA_W'(s1x_reg); mul_req.b = MB_W'(dy_reg); end
                    3'd3: begin mul_req.a = MA_W'(s1y_reg); mul_req.b = MB_W'(dx_reg); end
                    3'd4: begin
                        mul_req.a = $signed(MA_W'(sp));
                        mul_req.b = MB_W'(dy_reg);
                    end
                    3'd5: begin mul_req.a = MA_W'(s2y_reg); mul_req.b = MB_W'(dx_reg); end
                    default: begin
                        mul_req.a = '0;
                        mul_req.b = '0;
                    end
                endcase
            end
            ST_SCALE_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = sel_reg ? MA_W'(s1y_reg) : MA_W'(s1x_reg);
                mul_req.b     = $signed(MB_W'(best_reg));
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    x1_reg <= s_data.start_x;
                    if (s_data.operation == OP_HEIGHT) begin
                        y1_reg <= HQ_TOP;
                        x2_reg <= s_data.start_x;
                        y2_reg <= HQ_BOTTOM;
                    end else begin
                        y1_reg <= s_data.start_y;
                        x2_reg <= s_data.end_x;
                        y2_reg <= s_data.end_y;
                    end
                end
            end
            ST_QMIN_GO: begin
                s1x_reg <= DIFF_W'(x2_reg) - DIFF_W'(x1_reg);
                s1y_reg <= DIFF_W'(y2_reg) - DIFF_W'(y1_reg);
            end
            ST_QMIN_WAIT: if (div_done) qmin_reg <= div_q;
            ST_QMAX_WAIT: if (div_done) qmax_reg <= div_q;
            ST_WINDOW: begin
                i_reg     <= lo_c[VIDX_W-1:0];
                hi_reg    <= hi_c[VIDX_W-1:0];
                qx_reg    <= QX_W'(lo_c[VIDX_W-1:0]) * QX_W'(sp);
                found_reg <= 1'b0;
                sel_reg   <= 1'b0;
            end
            ST_READ1: h0_reg <= ram_q;
            ST_SETUP: begin
                s2y_reg  <= DIFF_W'($signed(ram_q)) - DIFF_W'(h0_reg);
                dy_reg   <= DIFF_W'(y1_reg) - DIFF_W'(h0_reg);
                dx_reg   <= DX_W'(x1_reg) - $signed(DX_W'(qx_reg));
                pidx_reg <= '0;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    pidx_reg <= pidx_reg + 3'd1;
                    unique case (pidx_reg)
                        3'd0:    den_reg <= mul_res;
                        3'd1:    den_reg <= den_reg - mul_res;
                        3'd2:    sn_reg  <= mul_res;
                        3'd3:    sn_reg  <= sn_reg - mul_res;
                        3'd4:    tn_reg  <= mul_res;
                        default: tn_reg  <= tn_reg - mul_res;
                    endcase
                end
            end
            ST_NORM: begin
                if (den_reg[PROD_W-1]) begin
                    den_reg <= -den_reg;
                    sn_reg  <= -sn_reg;
                    tn_reg  <= -tn_reg;
                end
            end
            ST_CHECK: begin
                seg_hit_reg <= !check_fail;
                tq_reg      <= TQ_W'(1) << T_BITS;
                rdiv_reg    <= {1'b0, tn_reg};
                qt_reg      <= '0;
                tcnt_reg    <= '0;
            end
            ST_DIVT: begin
                rdiv_reg <= t_ge ? (r_sh - den_ext) : r_sh;
                qt_reg   <= qt_n;
                tcnt_reg <= tcnt_reg + 5'd1;
                if (tdiv_last) tq_reg <= qt_n;
            end
            ST_UPDATE: begin
                // keep the earlier hit on a tie
                if (seg_hit_reg && (!found_reg || (tq_reg < best_reg))) begin
                    best_reg <= tq_reg;
                end
                found_reg <= found_reg || seg_hit_reg;
                if (more_segs) begin
                    i_reg  <= i_reg + VIDX_W'(1);
                    qx_reg <= qx_reg + QX_W'(sp);
                end
            end
            ST_ROUND: begin
                neg_reg <= mul_res[PROD_W-1];
                mag_reg <= mul_res[PROD_W-1] ? PROD_W'(-mul_res) : PROD_W'(mul_res);
            end
            ST_POINT: begin
                if (sel_reg) begin
                    py_reg <= pbase + $signed(sval);
                end else begin
                    px_reg <= pbase + $signed(sval);
                end
                sel_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_data_reg.hit     <= found_reg;
            m_data_reg.point_x <= found_reg ? px_reg : '0;
            m_data_reg.point_y <= found_reg ? py_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: tb/tb_polyline_segment_intersect_core.sv
// Self-checking testbench for polyline_segment_intersect_core: directed rows, then random
// requests over several spacings, checked against a built-in terrain crossing predictor.
// Depends on plsi_pkg and the core under src.
`default_nettype none

module tb_polyline_segment_intersect_core;
    timeunit 1ns;
    timeprecision 1ps;

    import plsi_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     PHASE_ITEMS = 155;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      cfg_wr_en;
    logic [SPACING_W-1:0] cfg_wr_data;

    // own copy of terrain state and spacing
    logic [COORD_W-1:0]   terrain_heights [NUM_VERTICES];
    logic [SPACING_W-1:0] spacing_reg;

    out_item_t expected_crossings [$];
    dir_row_t  directed_rows [$];
    int        fail_count;
    int        accepted_count;
    longint    cycle_count;
    bit        calm;

    polyline_segment_intersect_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint scale_by_t(longint unsigned tq, longint s);
        longint unsigned m;
        longint unsigned p;
        m = (s < 0) ? longint'(-s) : longint'(s);
        p = (tq * m + (64'd1 << (T_BITS - 1))) >> T_BITS;
        return (s < 0) ? -longint'(p) : longint'(p);
    endfunction

    // nearest crossing of the query segment with terrain segments in its window
    function automatic out_item_t predict_crossing(longint x1, longint y1, longint x2, longint y2);
        longint sp, lo, hi, i, h0, h1;
        logic signed [127:0] s1x, s1y, s2x, s2y, dx, dy, den, sn, tn;
        longint unsigned tq, best;
        bit found;
        out_item_t r;
        sp = (spacing_reg == 0) ? 1 : longint'(spacing_reg);
        lo = ((x1 < x2 ? x1 : x2) / sp) - 1;
        hi = ((x1 < x2 ? x2 : x1) / sp) + 2;
        if (lo < 0) lo = 0;
        if (hi > NUM_VERTICES - 1) hi = NUM_VERTICES - 1;
        s1x = x2 - x1;
        s1y = y2 - y1;
        found = 0;
        best = 0;
        for (i = lo; i < hi; i++) begin
            h0 = longint'($signed(terrain_heights[i]));
            h1 = longint'($signed(terrain_heights[i + 1]));
            s2x = sp;
            s2y = h1 - h0;
            dx = x1 - i * sp;
            dy = y1 - h0;
            den = s1x * s2y - s1y * s2x;
            if (den == 0) continue;
            sn = s1x * dy - s1y * dx;
            tn = s2x * dy - s2y * dx;
            if (den < 0) begin
                den = -den;
                sn = -sn;
                tn = -tn;
            end
            if (sn < 0 || sn > den || tn < 0 || tn > den) continue;
            tq = longint'((tn <<< T_BITS) / den);
            if (!found || tq < best) best = tq;
            found = 1;
        end
        r = '0;
        if (found) begin
            r.hit = 1'b1;
            r.point_x = 32'(x1 + scale_by_t(best, longint'(s1x)));
            r.point_y = 32'(y1 + scale_by_t(best, longint'(s1y)));
        end
        return r;
    endfunction

    // update terrain state for one request; tells whether it gives a result
    function automatic bit apply_request(in_item_t it, output out_item_t r);
        r = '0;
        case (it.operation)
            OP_WRITE: begin
                terrain_heights[it.vertex_index] = it.vertex_height;
                return 0;
            end
            OP_SEG: begin
                r = predict_crossing(it.start_x, it.start_y, it.end_x, it.end_y);
                return 1;
            end
            OP_HEIGHT: begin
                r = predict_crossing(it.start_x, HQ_TOP, it.start_x, HQ_BOTTOM);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $signed(32'($urandom_range(2047))) - 32'sd1024;
            1: return $signed(32'($urandom_range(2097151))) - 32'sd1048576;
            2: return $signed(32'($urandom_range(134217727))) - 32'sd67108864;
            default: return $signed($urandom);
        endcase
    endfunction

    // random request, mostly queries placed near the terrain so that crossings occur
    function automatic in_item_t make_request();
        in_item_t it;
        longint sp, base, h, r;
        int unsigned v, pick;
        it.operation     = 2'($urandom);
        it.vertex_index  = 8'($urandom);
        it.vertex_height = rand_coord();
        it.start_x = $signed($urandom);
        it.start_y = $signed($urandom);
        it.end_x   = $signed($urandom);
        it.end_y   = $signed($urandom);
        pick = $urandom_range(99);
        sp = (spacing_reg == 0) ? 1 : longint'(spacing_reg);
        v  = $urandom_range(NUM_VERTICES - 1);
        base = longint'(v) * sp + longint'($urandom_range(32'hffffffff)) % sp;
        h = longint'($signed(terrain_heights[v]));
        r = longint'(rand_coord());
        if (pick < 22) begin
            it.operation = OP_WRITE;
        end else if (pick < 25) begin
            it.operation = 2'd3;
        end else if (pick < 26) begin
            // far-reaching query over the full coordinate range
            it.operation = ($urandom_range(1) != 0) ? OP_SEG : OP_HEIGHT;
        end else if (pick < 62) begin
            it.operation = OP_SEG;
            it.start_x = clamp32(base);
            it.end_x   = clamp32(base + longint'($urandom_range(32'hffffffff)) % (4 * sp)
                                  - 2 * sp);
            if ($urandom_range(3) != 0) begin
                it.start_y = clamp32(h + r);
                it.end_y   = clamp32(h - r);
            end
        end else begin
            it.operation = OP_HEIGHT;
            it.start_x = ($urandom_range(3) == 0) ? clamp32(longint'(v) * sp) : clamp32(base);
        end
        return it;
    endfunction

    function automatic void add_row(logic [1:0] op, int idx, longint hgt, longint sx,
                                    longint sy, longint ex, longint ey, bit typed,
                                    bit hit, longint px, longint py);
        dir_row_t d;
        d.item.operation     = op;
        d.item.vertex_index  = 8'(idx);
        d.item.vertex_height = hgt[31:0];
        d.item.start_x       = sx[31:0];
        d.item.start_y       = sy[31:0];
        d.item.end_x         = ex[31:0];
        d.item.end_y         = ey[31:0];
        d.typed              = typed;
        d.result.hit         = hit;
        d.result.point_x     = px[31:0];
        d.result.point_y     = py[31:0];
        directed_rows.push_back(d);
    endfunction

    // offer one request, wait for its handshake, then record what it should produce
    task automatic send_request(in_item_t it, bit typed, out_item_t typed_result);
        int gap;
        out_item_t r;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 15) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        accepted_count++;
        if (apply_request(it, r)) expected_crossings.push_back(typed ? typed_result : r);
    endtask

    // spacing write, only with the block drained
    task automatic write_spacing(logic [SPACING_W-1:0] value);
        s_valid <= 1'b0;
        wait (expected_crossings.size() == 0);
        repeat (200) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        spacing_reg = value;
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        bit held;
        held = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!held && accepted_count >= 300) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_crossings.size() == 0) begin
                $error("result with no request pending: hit=%0d x=%0d y=%0d",
                       m_data.hit, m_data.point_x, m_data.point_y);
                fail_count++;
            end else begin
                e = expected_crossings.pop_front();
                if (m_data.hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, m_data.hit);
                    fail_count++;
                end
                if (m_data.point_x !== e.point_x) begin
                    $error("point_x: expected %0d, got %0d", e.point_x, m_data.point_x);
                    fail_count++;
                end
                if (m_data.point_y !== e.point_y) begin
                    $error("point_y: expected %0d, got %0d", e.point_y, m_data.point_y);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [SPACING_W-1:0] spacings [7];
        out_item_t none;
        int p, n;
        fail_count     = 0;
        accepted_count = 0;
        calm           = 0;
        none           = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        spacing_reg    = SPACING_RESET;
        foreach (terrain_heights[k]) terrain_heights[k] = '0;
        spacings = '{SPACING_W'(65536), SPACING_W'(1), SPACING_W'(2147483647), SPACING_W'(0),
                     SPACING_W'(1048576), SPACING_W'(3000), SPACING_W'($urandom)};

        // flat terrain after reset, empty windows, parallel lines
        add_row(OP_HEIGHT, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(OP_HEIGHT, 0, 0, -327680, 0, 0, 0, 1, 0, 0, 0);
        add_row(OP_HEIGHT, 0, 0, 2147483647, 0, 0, 0, 1, 0, 0, 0);
        add_row(OP_SEG, 0, 0, 0, 0, 131072, 0, 1, 0, 0, 0);
        add_row(OP_SEG, 0, 0, 0, 65536, 131072, -65536, 1, 1, 65536, 0);
        // height extremes, unknown operation, vertex ties, far-reaching queries
        add_row(OP_WRITE, 0, 2147483647, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 255, -64'sd2147483648, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 1, 131072, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(2'd3, 255, -1, -1, -1, -1, -1, 0, 0, 0, 0);
        add_row(OP_HEIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_HEIGHT, 0, 0, 32768, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_HEIGHT, 0, 0, 196608, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_HEIGHT, 0, 0, 254 * 65536 + 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_SEG, 0, 0, 131072, 65536, 196608, 0, 0, 0, 0, 0);
        add_row(OP_SEG, 0, 0, 196608, 0, 131072, 65536, 0, 0, 0, 0);
        add_row(OP_SEG, 0, 0, -64'sd2147483648, -64'sd2147483648, 2147483647, 2147483647,
                0, 0, 0, 0);
        add_row(OP_SEG, 0, 0, 2147483647, -64'sd2147483648, -64'sd2147483648, 2147483647,
                0, 0, 0, 0);
        add_row(OP_HEIGHT, 0, 0, -64'sd2147483648, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 128, -1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_SEG, 0, 0, 128 * 65536, 65536, 128 * 65536, -65536, 0, 0, 0, 0);

        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_request(directed_rows[k].item, directed_rows[k].typed,
                         directed_rows[k].result);

        for (p = 0; p < 7; p++) begin
            write_spacing(spacings[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                calm = (accepted_count >= 550 && accepted_count < 720);
                send_request(make_request(), 0, none);
            end
        end
        s_valid <= 1'b0;
        calm = 0;

        wait (expected_crossings.size() == 0);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/plsi_pkg.sv
src/plsi_height_ram.sv
src/plsi_mul.sv
src/plsi_win_div.sv
src/polyline_segment_intersect_core.sv
tb/tb_polyline_segment_intersect_core.sv
